@@ src/bma_pkg.sv @@
package bma_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int LENGTH_RESET    = 8;
	localparam int SUM_W_DEF       = SAMPLE_BITS_DEF + $clog2(WINDOW_MAX_DEF);
	localparam int LEN_W_DEF       = $clog2(WINDOW_MAX_DEF + 1);

	localparam logic FUNC_SAMPLE  = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	typedef struct packed {
		logic valid;
		logic avg;
		logic neg;
	} bma_ctl_t;

endpackage

@@ src/bma_ram.sv @@
module bma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read-first: a read and a write at the same address return the old entry.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[addr];
		end
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/bma_div_cell.sv @@
module bma_div_cell import bma_pkg::*; #(
	parameter int SUM_W = SUM_W_DEF,
	parameter int LEN_W = LEN_W_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  bma_ctl_t         ctl_in,
	input  logic [LEN_W-1:0] den_in,
	input  logic [LEN_W-1:0] rem_in,
	input  logic [SUM_W-1:0] num_in,
	output bma_ctl_t         ctl_q,
	output logic [LEN_W-1:0] den_q,
	output logic [LEN_W-1:0] rem_q,
	output logic [SUM_W-1:0] num_q
);

	logic [LEN_W:0]   trial;
	logic [LEN_W:0]   diff;
	logic             fits;
	logic [LEN_W-1:0] rem_n;
	logic [SUM_W-1:0] num_n;

	// With avg set, one restoring step: the next dividend bit enters the
	// remainder and one quotient bit shifts into the bottom of the word.
	always_comb begin
		trial = {rem_in, num_in[SUM_W-1]};
		diff  = trial - {1'b0, den_in};
		fits  = (trial >= {1'b0, den_in});
		if (ctl_in.avg) begin
			rem_n = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
			num_n = {num_in[SUM_W-2:0], fits};
		end else begin
			rem_n = rem_in;
			num_n = num_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_q <= den_in;
			rem_q <= rem_n;
			num_q <= num_n;
		end
	end

endmodule

@@ src/boxcar_moving_average.sv @@
// Boxcar moving average: takes one transfer per clock while the output is not
// stalled, and returns one result per sample, none per restart. A sample passes
// through until the window has filled; after that the result is the running
// window sum divided by the window length, truncated toward zero. An accepted
// transfer passes through the sum stage, the row of divider cells that produces
// one quotient bit each, and the output register. Back-pressure on the output
// freezes the whole pipeline.
// After reset the block is ready at once; the window store needs no clearing.
// Issue a restart after changing the window length.
module boxcar_moving_average import bma_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int LEN_W  = $clog2(WINDOW_MAX + 1),
	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LEN_W-1:0]  cfg_data,     // window_length
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata, // sample
	input  logic              s_axis_tuser, // func
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata, // smoothed
	output logic              m_axis_tuser  // averaged
);

	localparam int POS_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int LEN_RST = (LENGTH_RESET > WINDOW_MAX) ? WINDOW_MAX : LENGTH_RESET;
	localparam logic signed [SUM_W:0] SAT_HI =
		(SUM_W + 1)'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [SUM_W:0] SAT_LO = -SAT_HI - (SUM_W + 1)'(1);

	logic [LEN_W-1:0] cfg_len_q;
	logic [LEN_W-1:0] fill_q;
	logic [POS_W-1:0] pos_q;
	logic signed [SUM_W-1:0] sum_q;

	logic adv;
	logic acc;
	logic acc_smp;
	logic acc_rst;
	logic [LEN_W-1:0] len_c;
	logic [POS_W-1:0] pos_eff;
	logic [LEN_W-1:0] pos_inc;
	logic             full_c;
	logic [SAMPLE_BITS-1:0] smp_in;
	logic [SAMPLE_BITS-1:0] old_smp;

	logic                   v_s1;
	logic                   full_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic [LEN_W-1:0]       len_s1;

	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] sum_n;
	logic [SUM_W-1:0]        mag;

	bma_ctl_t         ctl_c [SUM_W+1];
	logic [LEN_W-1:0] den_c [SUM_W+1];
	logic [LEN_W-1:0] rem_c [SUM_W+1];
	logic [SUM_W-1:0] num_c [SUM_W+1];

	logic signed [SUM_W:0]  quo;
	logic [SAMPLE_BITS-1:0] res;

	logic                   out_v_q;
	logic [SAMPLE_BITS-1:0] out_data_q;
	logic                   out_avg_q;

	assign adv           = !out_v_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;
	assign acc           = s_axis_tvalid && adv;
	assign acc_smp       = acc && (s_axis_tuser == FUNC_SAMPLE);
	assign acc_rst       = acc && (s_axis_tuser == FUNC_RESTART);
	assign smp_in        = s_axis_tdata[SAMPLE_BITS-1:0];

	always_comb begin
		if (cfg_len_q == '0) begin
			len_c = LEN_W'(1);
		end else if (cfg_len_q > LEN_W'(WINDOW_MAX)) begin
			len_c = LEN_W'(WINDOW_MAX);
		end else begin
			len_c = cfg_len_q;
		end
		pos_eff = (LEN_W'(pos_q) >= len_c) ? '0 : pos_q;
		pos_inc = LEN_W'(pos_eff) + LEN_W'(1);
		full_c  = (fill_q >= len_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len_q <= LEN_W'(LEN_RST);
		end else if (cfg_valid && cfg_ready) begin
			cfg_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
		end else if (acc_rst) begin
			fill_q <= '0;
			pos_q  <= '0;
		end else if (acc_smp) begin
			if (!full_c) begin
				fill_q <= fill_q + LEN_W'(1);
			end
			pos_q <= (pos_inc >= len_c) ? '0 : pos_inc[POS_W-1:0];
		end
	end

	bma_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW_MAX)
	) u_window (
		.clk  (clk),
		.we   (acc_smp),
		.re   (acc_smp),
		.addr (pos_eff),
		.wdata(smp_in),
		.rdata(old_smp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc_smp;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && acc_smp) begin
			full_s1 <= full_c;
			smp_s1  <= smp_in;
			len_s1  <= len_c;
		end
	end

	always_comb begin
		old_ext = full_s1 ? SUM_W'($signed(old_smp)) : '0;
		sum_n   = sum_q + SUM_W'($signed(smp_s1)) - old_ext;
		mag     = sum_n[SUM_W-1] ? -sum_n : sum_n;
	end

	// A restart taken in the same cycle comes after the item in the sum stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (acc_rst) begin
			sum_q <= '0;
		end else if (adv && v_s1) begin
			sum_q <= sum_n;
		end
	end

	assign ctl_c[0] = '{valid: v_s1, avg: full_s1, neg: sum_n[SUM_W-1]};
	assign den_c[0] = len_s1;
	assign rem_c[0] = '0;
	assign num_c[0] = full_s1 ? mag : SUM_W'($signed(smp_s1));

	for (genvar i = 0; i < SUM_W; i++) begin : g_cell
		bma_div_cell #(
			.SUM_W(SUM_W),
			.LEN_W(LEN_W)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.ctl_in(ctl_c[i]),
			.den_in(den_c[i]),
			.rem_in(rem_c[i]),
			.num_in(num_c[i]),
			.ctl_q (ctl_c[i+1]),
			.den_q (den_c[i+1]),
			.rem_q (rem_c[i+1]),
			.num_q (num_c[i+1])
		);
	end

	always_comb begin
		quo = ctl_c[SUM_W].neg ? -$signed({1'b0, num_c[SUM_W]}) : $signed({1'b0, num_c[SUM_W]});
		if (!ctl_c[SUM_W].avg) begin
			res = num_c[SUM_W][SAMPLE_BITS-1:0];
		end else if (quo > SAT_HI) begin
			res = SAT_HI[SAMPLE_BITS-1:0];
		end else if (quo < SAT_LO) begin
			res = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			res = quo[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= ctl_c[SUM_W].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res;
			out_avg_q  <= ctl_c[SUM_W].avg;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = DATA_W'(out_data_q);
	assign m_axis_tuser  = out_avg_q;

	a_smp_enters_sum_stage: assert property (@(posedge clk) disable iff (!arst_n)
		acc_smp |=> v_s1)
		else $error("accepted sample did not reach the sum stage");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc_rst |=> (fill_q == '0) && (pos_q == '0) && (sum_q == '0))
		else $error("restart left window state behind");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> v_s1 && $stable(smp_s1) && $stable(sum_q))
		else $error("sum stage changed during a stall");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		acc_smp && full_c |=> $stable(fill_q))
		else $error("fill count moved after the window was full");

endmodule

@@ sim/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bma_pkg::*;

	localparam int LATENCY     = SAMPLE_BITS_DEF + $clog2(WINDOW_MAX_DEF) + 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 12;
	localparam int FIXED       = 9;
	localparam int PHASE_ITEMS = 150;
	localparam int HOLD_PHASE  = 8;

	typedef struct packed {
		logic signed [SAMPLE_BITS_DEF-1:0] smoothed;
		logic                              averaged;
	} smooth_t;

	typedef struct packed {
		logic                              func;
		logic signed [SAMPLE_BITS_DEF-1:0] sample;
		logic                              known;
		smooth_t                           want;
	} stim_row_t;

	logic                       clk           = 1'b0;
	logic                       arst_n        = 1'b0;
	logic                       cfg_valid     = 1'b0;
	logic                       cfg_ready;
	logic [LEN_W_DEF-1:0]       cfg_data      = '0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [SAMPLE_BITS_DEF-1:0] s_axis_tdata  = '0;
	logic                       s_axis_tuser  = FUNC_SAMPLE;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [SAMPLE_BITS_DEF-1:0] m_axis_tdata;
	logic                       m_axis_tuser;

	// Shadow of the block state, advanced once per accepted input transfer.
	logic signed [SAMPLE_BITS_DEF-1:0] win_mem [WINDOW_MAX_DEF] = '{default: '0};
	logic signed [SUM_W_DEF-1:0]       win_sum = '0;
	logic [LEN_W_DEF-1:0]              win_len = LEN_W_DEF'(LENGTH_RESET);
	int                                fill_cnt = 0;
	int                                wr_pos = 0;

	smooth_t expected_smooth [$];

	int errors = 0;
	int cycles = 0;
	int hold_req = 0;
	bit quiet = 1'b0;
	int n_samples = 0;
	int n_restarts = 0;
	int n_results = 0;
	int n_means = 0;
	int n_cfg = 0;

	stim_row_t directed_rows [23] = '{
		'{FUNC_SAMPLE,  16'sh7FFF, 1'b1, '{16'sh7FFF, 1'b0}},
		'{FUNC_SAMPLE,  16'sh8000, 1'b1, '{16'sh8000, 1'b0}},
		'{FUNC_SAMPLE,  16'sh0000, 1'b1, '{16'sh0000, 1'b0}},
		'{FUNC_SAMPLE,  16'shFFFF, 1'b1, '{16'shFFFF, 1'b0}},
		'{FUNC_SAMPLE,  16'sh0001, 1'b1, '{16'sh0001, 1'b0}},
		'{FUNC_SAMPLE,  16'sh5555, 1'b1, '{16'sh5555, 1'b0}},
		'{FUNC_SAMPLE,  16'shAAAA, 1'b1, '{16'shAAAA, 1'b0}},
		'{FUNC_SAMPLE,  16'sh7FFF, 1'b1, '{16'sh7FFF, 1'b0}},
		'{FUNC_SAMPLE,  16'sh1234, 1'b0, '{16'sh0000, 1'b0}},
		'{FUNC_SAMPLE,  16'sh8000, 1'b0, '{16'sh0000, 1'b0}},
		'{FUNC_RESTART, 16'sh7FFF, 1'b0, '{16'sh0000, 1'b0}},
		'{FUNC_SAMPLE,  16'sh8000, 1'b1, '{16'sh8000, 1'b0}},
		'{FUNC_SAMPLE,  16'sh8000, 1'b1, '{16'sh8000, 1'b0}},
		'{FUNC_SAMPLE,  16'sh8000, 1'b1, '{16'sh8000, 1'b0}},
		'{FUNC_SAMPLE,  16'sh8000, 1'b1, '{16'sh8000, 1'b0}},
		'{FUNC_SAMPLE,  16'sh8000, 1'b1, '{16'sh8000, 1'b0}},
		'{FUNC_SAMPLE,  16'sh8000, 1'b1, '{16'sh8000, 1'b0}},
		'{FUNC_SAMPLE,  16'sh8000, 1'b1, '{16'sh8000, 1'b0}},
		'{FUNC_SAMPLE,  16'sh8000, 1'b1, '{16'sh8000, 1'b0}},
		'{FUNC_SAMPLE,  16'sh8000, 1'b1, '{16'sh8000, 1'b1}},
		'{FUNC_SAMPLE,  16'sh7FFF, 1'b0, '{16'sh0000, 1'b0}},
		'{FUNC_RESTART, 16'sh0000, 1'b0, '{16'sh0000, 1'b0}},
		'{FUNC_SAMPLE,  16'sh4321, 1'b1, '{16'sh4321, 1'b0}}
	};

	int  phase_len [FIXED]     = '{64, 1, 0, 127, 8, 3, 64, 100, 5};
	bit  phase_restart [FIXED] = '{1, 0, 1, 1, 0, 1, 0, 1, 1};
	int  phase_bias [FIXED]    = '{1, 1, 0, 2, 2, 0, 0, 0, 0};

	boxcar_moving_average i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic advance_window(input logic func, input logic signed [15:0] smp,
			output bit produced, output smooth_t res);
		int len;
		int pos;
		int mean;
		logic signed [SAMPLE_BITS_DEF-1:0] oldest;
		len = (win_len == 0) ? 1 :
			((win_len > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : int'(win_len));
		produced = 1'b0;
		res = '0;
		if (func == FUNC_RESTART) begin
			fill_cnt = 0;
			wr_pos = 0;
			win_sum = '0;
			return;
		end
		pos = (wr_pos >= len) ? 0 : wr_pos;
		oldest = win_mem[pos];
		win_mem[pos] = smp;
		wr_pos = (pos + 1 >= len) ? 0 : pos + 1;
		produced = 1'b1;
		if (fill_cnt < len) begin
			fill_cnt++;
			win_sum = win_sum + smp;
			res.smoothed = smp;
			res.averaged = 1'b0;
		end else begin
			win_sum = win_sum + smp - oldest;
			mean = win_sum / len;
			if (mean > 32767)
				mean = 32767;
			if (mean < -32768)
				mean = -32768;
			res.smoothed = mean[SAMPLE_BITS_DEF-1:0];
			res.averaged = 1'b1;
		end
	endtask

	function automatic logic signed [15:0] pick_sample(input int bias);
		int r;
		r = $urandom_range(0, 15);
		if (bias == 1 && r < 10)
			return 16'sh7FFF - 16'($urandom_range(0, 7));
		if (bias == 2 && r < 10)
			return 16'sh8000 + 16'($urandom_range(0, 7));
		case (r)
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'shFFFF;
			3: return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic func, input logic signed [15:0] smp,
			input bit known, input smooth_t want);
		bit produced;
		smooth_t predicted;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= smp;
		do
			@(posedge clk);
		while (!s_axis_tready);
		advance_window(func, smp, produced, predicted);
		if (func == FUNC_RESTART)
			n_restarts++;
		else
			n_samples++;
		if (produced)
			expected_smooth.push_back(known ? want : predicted);
	endtask

	task automatic sender_gap(input int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_smooth.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W_DEF-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		win_len = value;
		n_cfg++;
	endtask

	initial begin : result_sink
		int stall_left;
		int calm_left;
		smooth_t want;
		smooth_t got;
		stall_left = 0;
		calm_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.smoothed = m_axis_tdata;
				got.averaged = m_axis_tuser;
				if (expected_smooth.size() == 0) begin
					$error("unexpected result: smoothed %0d, averaged %0d",
						got.smoothed, got.averaged);
					errors++;
				end else begin
					want = expected_smooth.pop_front();
					n_results++;
					if (want.averaged)
						n_means++;
					if (got.smoothed !== want.smoothed) begin
						$error("smoothed: expected %0d, got %0d",
							want.smoothed, got.smoothed);
						errors++;
					end
					if (got.averaged !== want.averaged) begin
						$error("averaged: expected %0d, got %0d",
							want.averaged, got.averaged);
						errors++;
					end
				end
			end
			if (hold_req != 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (quiet || calm_left > 0) begin
				m_axis_tready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
			end else begin
				case ($urandom_range(0, 9))
					0, 1: begin
						stall_left = $urandom_range(1, 8) - 1;
						m_axis_tready <= 1'b0;
					end
					2: begin
						calm_left = $urandom_range(20, 80);
						m_axis_tready <= 1'b1;
					end
					default: m_axis_tready <= 1'b1;
				endcase
			end
		end
	end

	initial begin : stimulus
		int ph;
		int i;
		int len;
		int eff;
		int bias;
		bit restart;
		bit gaps_on;
		logic func;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The window length is still at its reset value here.
		foreach (directed_rows[k]) begin
			send_item(directed_rows[k].func, directed_rows[k].sample,
				directed_rows[k].known, directed_rows[k].want);
			if ($urandom_range(0, 3) == 0)
				sender_gap($urandom_range(1, 8));
		end

		// The first phase fills all 64 entries, so later length changes without
		// a restart never read an entry that has not been written.
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph < FIXED) begin
				len = phase_len[ph];
				restart = phase_restart[ph];
				bias = phase_bias[ph];
			end else begin
				len = $urandom_range(0, 127);
				restart = $urandom_range(0, 1);
				bias = $urandom_range(0, 2);
			end
			settle();
			write_length(LEN_W_DEF'(len));
			if (ph == PHASES - 1)
				quiet = 1'b1;
			gaps_on = !quiet && ($urandom_range(0, 3) != 0);
			eff = (len == 0) ? 1 : ((len > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : len);
			if (restart)
				send_item(FUNC_RESTART, 16'($urandom), 1'b0, '0);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == HOLD_PHASE && i == 20) begin
					hold_req = 300;
					gaps_on = 1'b0;
				end
				if (ph == 0 && i < WINDOW_MAX_DEF)
					func = FUNC_SAMPLE;
				else if ($urandom_range(0, 3 * eff + 10) == 0)
					func = FUNC_RESTART;
				else
					func = FUNC_SAMPLE;
				send_item(func, pick_sample(bias), 1'b0, '0);
				if (gaps_on && $urandom_range(0, 4) == 0)
					sender_gap($urandom_range(1, 8));
			end
		end

		settle();
		$display("Checked %0d results (%0d window means) from %0d samples and %0d restarts,",
			n_results, n_means, n_samples, n_restarts);
		$display("across %0d window length settings including 0, 1, 64 and out of range.",
			n_cfg);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
